@@ src/xtea_block_cipher_assert.svh @@
// assertion macros shared by the xtea cipher rtl
`ifndef XTEA_BLOCK_CIPHER_ASSERT_SVH
`define XTEA_BLOCK_CIPHER_ASSERT_SVH

// same-cycle implication, sampled on clk and idle while rst_n is low
`define XTEA_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk and idle while rst_n is low
`define XTEA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/xtea_pkg.sv @@
// types, constants and the round function of the xtea cipher
package xtea_pkg;

    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;
    localparam int KEY_WORDS = 4;

    localparam logic [DATA_W-1:0] XTEA_DELTA = 32'h9E37_79B9;

    // register indexes, byte address is four times the index
    localparam logic [REG_IDX_W-1:0] REG_KEY0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KEY2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KEY3 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MODE = 3'd4;

    typedef logic [KEY_WORDS-1:0][DATA_W-1:0] key_words_t;

    typedef struct packed {
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
        logic              last;
    } block_t;

    function automatic logic [DATA_W-1:0] xtea_mix(
        input logic [DATA_W-1:0] x,
        input logic [DATA_W-1:0] s,
        input logic [DATA_W-1:0] kw
    );
        xtea_mix = (((x << 4) ^ (x >> 5)) + x) ^ (s + kw);
    endfunction

endpackage

@@ src/xtea_in_if.sv @@
// input channel: one plaintext or ciphertext block per transaction
interface xtea_in_if;
    import xtea_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] first_word;
    logic [DATA_W-1:0] second_word;
    logic              last_block;

    modport source (output valid, output first_word, output second_word,
                    output last_block, input ready);
    modport sink   (input valid, input first_word, input second_word,
                    input last_block, output ready);
endinterface

@@ src/xtea_out_if.sv @@
// output channel: one processed block per transaction
interface xtea_out_if;
    import xtea_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result_first;
    logic [DATA_W-1:0] result_second;
    logic              result_last;

    modport source (output valid, output result_first, output result_second,
                    output result_last, input ready);
    modport sink   (input valid, input result_first, input result_second,
                    input result_last, output ready);
endinterface

@@ src/xtea_half_round.sv @@
// one feistel half-round of xtea with its pipeline register
module xtea_half_round
    import xtea_pkg::*;
#(
    parameter logic [31:0] ENC_SUM = 32'h0000_0000,
    parameter logic [31:0] DEC_SUM = 32'h0000_0000,
    parameter bit          ODD     = 1'b0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       decrypt,
    input  key_words_t key,
    input  logic       valid,
    input  block_t     data,
    output logic       valid_out,
    output block_t     data_out
);

    logic        valid_reg;
    block_t      data_reg;
    block_t      data_next;
    logic        update_y;
    logic [31:0] sum;
    logic [1:0]  key_idx;
    logic [31:0] src_word;
    logic [31:0] dst_word;
    logic [31:0] mixed;
    logic [31:0] new_word;

    // encryption updates y on even half-rounds, decryption on odd ones
    assign update_y = (ODD == decrypt);
    assign sum      = decrypt ? DEC_SUM : ENC_SUM;
    assign key_idx  = update_y ? sum[1:0] : sum[12:11];
    assign src_word = update_y ? data.z : data.y;
    assign dst_word = update_y ? data.y : data.z;
    assign mixed    = xtea_mix(src_word, sum, key[key_idx]);
    assign new_word = decrypt ? (dst_word - mixed) : (dst_word + mixed);

    always_comb
    begin
        data_next = data;
        if (update_y)
        begin
            data_next.y = new_word;
        end
        else
        begin
            data_next.z = new_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

@@ src/xtea_block_cipher.sv @@
// xtea ecb cipher: apb key and mode registers, fully pipelined rounds
//
// usage: write key words 0..3 at byte addresses 0x00..0x0c and the direction
// at 0x10 (bit 0: 0 encrypts, 1 decrypts) over the apb port while no block is
// in flight. blocks enter on the feed channel as two 32-bit halves plus a
// last-block flag, and leave on the result channel in the same order with
// the flag copied through.
// each half-round has its own pipeline stage, so the block holds
// 2*CYCLE_COUNT stages (64 by default) followed by a two-entry output buffer.
// an accepted block passes all half-round stages and then the output buffer.
// throughput: one block per clock when not stalled, paced by the stages.
// when the receiver stalls the output buffer fills, then feed.ready drops and
// the whole pipeline holds; nothing is dropped or repeated. feed.ready comes
// from a register, with no path from result.ready.
// reset (rst_n low, asynchronous) clears keys, mode, all stage valid bits and
// the output buffer; the block accepts input as soon as reset is released.
`include "xtea_block_cipher_assert.svh"

module xtea_block_cipher
    import xtea_pkg::*;
#(
    parameter int CYCLE_COUNT = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    xtea_in_if.sink           feed,
    xtea_out_if.source        result
);

    localparam int STAGES = 2 * CYCLE_COUNT;

    // configuration registers
    key_words_t           key_reg;
    logic                 mode_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= '0;
            mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_KEY0: key_reg[0] <= pwdata;
                REG_KEY1: key_reg[1] <= pwdata;
                REG_KEY2: key_reg[2] <= pwdata;
                REG_KEY3: key_reg[3] <= pwdata;
                REG_MODE: mode_reg   <= pwdata[0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_KEY0: prdata = key_reg[0];
            REG_KEY1: prdata = key_reg[1];
            REG_KEY2: prdata = key_reg[2];
            REG_KEY3: prdata = key_reg[3];
            REG_MODE: prdata = {{(DATA_W-1){1'b0}}, mode_reg};
            default:  prdata = '0;
        endcase
    end

    // output buffer, two entries
    block_t     buf_reg [2];
    logic       head_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       advance;
    logic       push;
    logic       pop;
    logic       wr_ptr;

    // half-round pipeline
    logic   stage_valid [0:STAGES];
    block_t stage_data  [0:STAGES];

    assign advance    = (count_reg != 2'd2);
    assign feed.ready = advance;

    assign stage_valid[0]     = feed.valid;
    assign stage_data[0].y    = feed.first_word;
    assign stage_data[0].z    = feed.second_word;
    assign stage_data[0].last = feed.last_block;

    for (genvar j = 0; j < STAGES; j++)
    begin : g_stage
        localparam int          RND     = j / 2;
        localparam bit          IS_ODD  = (j % 2) == 1;
        localparam logic [31:0] ENC_SUM = XTEA_DELTA * 32'(RND + (IS_ODD ? 1 : 0));
        localparam logic [31:0] DEC_SUM =
            XTEA_DELTA * 32'(CYCLE_COUNT - RND - (IS_ODD ? 1 : 0));

        xtea_half_round #(
            .ENC_SUM (ENC_SUM),
            .DEC_SUM (DEC_SUM),
            .ODD     (IS_ODD)
        ) u_half_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .decrypt   (mode_reg),
            .key       (key_reg),
            .valid     (stage_valid[j]),
            .data      (stage_data[j]),
            .valid_out (stage_valid[j+1]),
            .data_out  (stage_data[j+1])
        );
    end

    assign push   = advance && stage_valid[STAGES];
    assign pop    = result.valid && result.ready;
    assign wr_ptr = head_reg ^ count_reg[0];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (pop)
            begin
                head_reg <= ~head_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr] <= stage_data[STAGES];
        end
    end

    assign result.valid         = (count_reg != 2'd0);
    assign result.result_first  = buf_reg[head_reg].y;
    assign result.result_second = buf_reg[head_reg].z;
    assign result.result_last   = buf_reg[head_reg].last;

    `XTEA_ASSERT_IMPL(a_count_bound, 1'b1, count_reg != 2'd3, "output buffer count overflow")
    `XTEA_ASSERT_NEXT(a_count_drain, pop && !push, count_reg == $past(count_reg) - 2'd1,
        "output buffer count did not drop after a pop")
    `XTEA_ASSERT_NEXT(a_stall_hold, !advance && stage_valid[STAGES], stage_valid[STAGES],
        "last stage lost its block during a stall")
    `XTEA_ASSERT_NEXT(a_entry_valid, advance, stage_valid[1] == $past(feed.valid),
        "first stage valid does not follow the accepted transaction")

endmodule

@@ sim/tb_top.sv @@
// self-checking testbench for the xtea ecb cipher: apb key setup, block traffic, result checks
`timescale 1ns / 100ps

module tb_top;
    import xtea_pkg::*;

    localparam int ROUNDS       = 32;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 2 * ROUNDS + 10;

    // unused register slot, writes there must be ignored
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    xtea_in_if  blk_in ();
    xtea_out_if blk_out ();

    xtea_block_cipher #(
        .CYCLE_COUNT (ROUNDS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .feed    (blk_in),
        .result  (blk_out)
    );

    // shadow copy of the cipher registers
    logic [DATA_W-1:0] cfg_key [KEY_WORDS];
    logic              cfg_decrypt;

    block_t block_q[$];
    block_t cipher_expect_q[$];

    int feed_idle_pct;
    int sink_stall_pct;
    int sink_hold_left;
    int mismatch_cnt;
    int cycle_cnt;

    always #2 clk = ~clk;

    function automatic logic [DATA_W-1:0] feistel_f(
        input logic [DATA_W-1:0] x,
        input logic [DATA_W-1:0] s,
        input logic [DATA_W-1:0] kw
    );
        return (((x << 4) ^ (x >> 5)) + x) ^ (s + kw);
    endfunction

    function automatic block_t xtea_predict(input block_t blk);
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
        logic [DATA_W-1:0] sum;
        block_t            res;
        y = blk.y;
        z = blk.z;
        if (!cfg_decrypt)
        begin
            sum = '0;
            for (int n = 0; n < ROUNDS; n++)
            begin
                y   = y + feistel_f(z, sum, cfg_key[sum[1:0]]);
                sum = sum + XTEA_DELTA;
                z   = z + feistel_f(y, sum, cfg_key[sum[12:11]]);
            end
        end
        else
        begin
            sum = XTEA_DELTA * ROUNDS;
            for (int n = 0; n < ROUNDS; n++)
            begin
                z   = z - feistel_f(y, sum, cfg_key[sum[12:11]]);
                sum = sum - XTEA_DELTA;
                y   = y - feistel_f(z, sum, cfg_key[sum[1:0]]);
            end
        end
        res.y    = y;
        res.z    = z;
        res.last = blk.last;
        return res;
    endfunction

    function automatic block_t mk_block(
        input logic [DATA_W-1:0] y,
        input logic [DATA_W-1:0] z,
        input logic              last
    );
        block_t b;
        b.y    = y;
        b.z    = z;
        b.last = last;
        return b;
    endfunction

    // mostly uniform words, with corner values mixed in
    function automatic logic [DATA_W-1:0] pick_word();
        logic [DATA_W-1:0] w;
        case ($urandom_range(15))
            0: w = '0;
            1: w = '1;
            2: w = 32'd1 << $urandom_range(31);
            3: w = ~(32'd1 << $urandom_range(31));
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < KEY_WORDS)
            cfg_key[idx[1:0]] = val;
        else if (idx == REG_MODE)
            cfg_decrypt = val[0];
    endtask

    task automatic load_cipher(
        input logic [DATA_W-1:0] k0,
        input logic [DATA_W-1:0] k1,
        input logic [DATA_W-1:0] k2,
        input logic [DATA_W-1:0] k3,
        input logic              decrypt
    );
        apb_write(REG_KEY0, k0);
        apb_write(REG_KEY1, k1);
        apb_write(REG_KEY2, k2);
        apb_write(REG_KEY3, k3);
        apb_write(REG_MODE, {31'd0, decrypt});
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (block_q.size() != 0 || cipher_expect_q.size() != 0);
    endtask

    // messages of random length, last flag on the final block of each
    task automatic queue_messages(input int n_blocks);
        int left;
        int len;
        @(negedge clk);
        left = n_blocks;
        while (left > 0)
        begin
            len = $urandom_range(1, 8);
            if (len > left)
                len = left;
            for (int i = 0; i < len; i++)
                block_q.push_back(mk_block(pick_word(), pick_word(), i == len - 1));
            left = left - len;
        end
    endtask

    task automatic set_idling(input int feed_pct, input int sink_pct);
        @(negedge clk);
        feed_idle_pct  = feed_pct;
        sink_stall_pct = sink_pct;
    endtask

    // feed driver
    always @(posedge clk)
    begin : feed_driver
        logic offer;
        if (rst_n)
        begin
            if (blk_in.valid && blk_in.ready)
            begin
                cipher_expect_q.push_back(xtea_predict(block_q[0]));
                void'(block_q.pop_front());
            end
            if (blk_in.valid && !blk_in.ready)
                offer = 1'b1;
            else
                offer = (block_q.size() != 0) && ($urandom_range(99) >= feed_idle_pct);
            blk_in.valid <= offer;
            if (offer)
            begin
                blk_in.first_word  <= block_q[0].y;
                blk_in.second_word <= block_q[0].z;
                blk_in.last_block  <= block_q[0].last;
            end
        end
    end

    // result monitor and receiver backpressure
    always @(posedge clk)
    begin : result_monitor
        block_t want;
        if (rst_n)
        begin
            if (blk_out.valid && blk_out.ready)
            begin
                if (cipher_expect_q.size() == 0)
                begin
                    $error("unexpected result transaction: first %h second %h last %b",
                           blk_out.result_first, blk_out.result_second, blk_out.result_last);
                    mismatch_cnt++;
                end
                else
                begin
                    want = cipher_expect_q.pop_front();
                    if (blk_out.result_first !== want.y)
                    begin
                        $error("result_first: expected %h, got %h", want.y, blk_out.result_first);
                        mismatch_cnt++;
                    end
                    if (blk_out.result_second !== want.z)
                    begin
                        $error("result_second: expected %h, got %h",
                               want.z, blk_out.result_second);
                        mismatch_cnt++;
                    end
                    if (blk_out.result_last !== want.last)
                    begin
                        $error("result_last: expected %b, got %b",
                               want.last, blk_out.result_last);
                        mismatch_cnt++;
                    end
                end
            end
            blk_out.ready <= (sink_hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // long receiver hold-off, counted down here
    always @(posedge clk)
    begin
        if (sink_hold_left != 0)
            sink_hold_left <= sink_hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        blk_in.valid      = 1'b0;
        blk_in.first_word = '0;
        blk_in.second_word = '0;
        blk_in.last_block = 1'b0;
        blk_out.ready     = 1'b0;
        feed_idle_pct     = 0;
        sink_stall_pct    = 0;
        sink_hold_left    = 0;
        mismatch_cnt      = 0;
        cycle_cnt         = 0;
        cfg_decrypt       = 1'b0;
        for (int i = 0; i < KEY_WORDS; i++)
            cfg_key[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset keys and mode: extremes of the block halves
        @(negedge clk);
        block_q.push_back(mk_block(32'h0000_0000, 32'h0000_0000, 1'b0));
        block_q.push_back(mk_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        block_q.push_back(mk_block(32'hFFFF_FFFF, 32'h0000_0000, 1'b0));
        block_q.push_back(mk_block(32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
        block_q.push_back(mk_block(32'h8000_0000, 32'h0000_0001, 1'b0));
        block_q.push_back(mk_block(32'h5555_5555, 32'hAAAA_AAAA, 1'b1));
        wait_drained();

        load_cipher(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F, 1'b0);
        @(negedge clk);
        block_q.push_back(mk_block(32'h4142_4344, 32'h4546_4748, 1'b0));
        block_q.push_back(mk_block(32'h0000_0000, 32'h0000_0000, 1'b0));
        block_q.push_back(mk_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        block_q.push_back(mk_block(32'hAAAA_AAAA, 32'h5555_5555, 1'b1));
        wait_drained();

        // ignored register slot, and a mode value wider than one bit
        apb_write(REG_SPARE, 32'hFFFF_FFFF);
        apb_write(REG_MODE, 32'hFFFF_FFFF);
        @(negedge clk);
        block_q.push_back(mk_block(32'h497D_F3D0, 32'h7206_12CB, 1'b0));
        block_q.push_back(mk_block(32'h0000_0000, 32'h0000_0000, 1'b0));
        block_q.push_back(mk_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        wait_drained();
        apb_write(REG_MODE, 32'hFFFF_FFFE);
        @(negedge clk);
        block_q.push_back(mk_block(32'h1234_5678, 32'h9ABC_DEF0, 1'b1));
        wait_drained();

        load_cipher('1, '1, '1, '1, 1'b1);
        @(negedge clk);
        block_q.push_back(mk_block(32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
        block_q.push_back(mk_block(32'hFFFF_FFFF, 32'h0000_0000, 1'b1));
        block_q.push_back(mk_block(32'h0000_0001, 32'h8000_0000, 1'b0));
        wait_drained();

        // no idling; the receiver holds off long enough to back up the pipeline
        load_cipher('1, '1, '1, '1, 1'b0);
        @(negedge clk);
        sink_hold_left = 400;
        queue_messages(160);
        wait_drained();
        load_cipher($urandom, $urandom, $urandom, $urandom, 1'b1);
        queue_messages(100);
        wait_drained();

        // sender idle, with a pause mid-run until the pipeline is empty
        set_idling(55, 0);
        load_cipher('0, '0, '0, '0, 1'b1);
        queue_messages(65);
        wait_drained();
        queue_messages(65);
        wait_drained();
        load_cipher($urandom, $urandom, $urandom, $urandom, 1'b0);
        queue_messages(130);
        wait_drained();

        set_idling(0, 55);
        load_cipher($urandom, $urandom, $urandom, $urandom, 1'b0);
        queue_messages(130);
        wait_drained();
        load_cipher(pick_word(), pick_word(), pick_word(), pick_word(), 1'b1);
        queue_messages(130);
        wait_drained();

        set_idling(38, 38);
        load_cipher(pick_word(), pick_word(), pick_word(), pick_word(), 1'b0);
        queue_messages(130);
        wait_drained();
        load_cipher($urandom, $urandom, $urandom, $urandom, 1'b1);
        queue_messages(130);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && cipher_expect_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
